// ===== hdl/kmdeb_pkg.sv =====
// Shared constants and types for the key matrix debouncer.
`timescale 1ns / 1ps
`default_nettype none

package kmdeb_pkg;

   // Matrix geometry
   localparam int ROWS = 8;
   localparam int COLS = 16;

   // Field widths
   localparam int ROW_W   = 3;
   localparam int PINS_W  = 16;
   localparam int COUNT_W = 8;

   // Quiet counter and debounce_count value after reset
   localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = COUNT_W'(5);

   // Columns beyond COLS read as off
   localparam logic [PINS_W-1:0] COL_MASK = PINS_W'((64'h1 << COLS) - 64'h1);

   typedef logic [ROW_W-1:0]   row_idx_type;
   typedef logic [PINS_W-1:0]  row_bits_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage : kmdeb_pkg

`default_nettype wire

// ===== hdl/key_matrix_debouncer.sv =====
// Key matrix debouncer top level: shadow/stable matrices and global quiet counter.
// A result is registered and appears in the cycle after its request is accepted.
// One request per cycle while no stalled result is held; compare, reload and matrix commit are combinational.
// The result register holds a stalled result; req_ready = !rsp_valid || rsp_ready.
// Reset (synchronous, active high): shadow and stable rows clear to zero,
// debounce_count and the quiet counter load 5, no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debouncer (
   input  wire                    clock,
   input  wire                    reset,
   // Configuration write
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  kmdeb_pkg::count_type   csr_debounce_count,
   // Row sample requests
   input  wire                    req_valid,
   output logic                   req_ready,
   input  kmdeb_pkg::row_idx_type req_row_index,
   input  kmdeb_pkg::row_bits_type req_column_pins,
   input  wire                    req_end_of_scan,
   // Results
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output kmdeb_pkg::row_bits_type rsp_stable_row,
   output logic                   rsp_bounce_seen,
   output logic                   rsp_settled,
   output logic                   rsp_debounce_busy
);
   import kmdeb_pkg::*;

   row_bits_type shadow_ff [ROWS];
   row_bits_type shadow_in [ROWS];
   row_bits_type stable_ff [ROWS];
   row_bits_type stable_in [ROWS];
   count_type    count_cfg_ff, count_cfg_in;
   count_type    quiet_ff, quiet_in;

   logic         rsp_valid_ff, rsp_valid_in;
   row_bits_type stable_row_ff, stable_row_in;
   logic         bounce_ff, bounce_in;
   logic         settled_ff, settled_in;
   logic         busy_ff, busy_in;

   logic         accept;
   logic         row_ok;
   row_bits_type cols;
   logic         changed;
   count_type    reload;
   count_type    quiet_mid;
   logic         dec;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Compare, reload, end-of-scan count and commit
   always_comb begin
      row_ok  = 32'(req_row_index) < ROWS;
      cols    = (~req_column_pins) & COL_MASK;
      changed = row_ok && (shadow_ff[req_row_index] != cols);
      reload  = (count_cfg_ff != '0) ? count_cfg_ff : count_type'(1);

      quiet_mid = changed ? reload : quiet_ff;
      dec       = req_end_of_scan && (quiet_mid != '0);
      quiet_in  = dec ? quiet_mid - count_type'(1) : quiet_mid;

      bounce_in  = changed && (quiet_ff != '0);
      settled_in = dec && (quiet_mid == count_type'(1));
      busy_in    = quiet_in != '0;

      for (int r = 0; r < ROWS; r++) begin
         shadow_in[r] = shadow_ff[r];
      end
      if (changed) begin
         shadow_in[req_row_index] = cols;
      end
      for (int r = 0; r < ROWS; r++) begin
         stable_in[r] = settled_in ? shadow_in[r] : stable_ff[r];
      end

      // On commit the sampled row's stable value is the new sample
      if (!row_ok) begin
         stable_row_in = '0;
      end else if (settled_in) begin
         stable_row_in = cols;
      end else begin
         stable_row_in = stable_ff[req_row_index];
      end

      count_cfg_in = (csr_valid && csr_ready) ? csr_debounce_count : count_cfg_ff;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   end

   // Control state and matrices
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_cfg_ff <= DEBOUNCE_RESET;
         quiet_ff     <= DEBOUNCE_RESET;
         for (int r = 0; r < ROWS; r++) begin
            shadow_ff[r] <= '0;
            stable_ff[r] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_cfg_ff <= count_cfg_in;
         if (accept) begin
            quiet_ff  <= quiet_in;
            shadow_ff <= shadow_in;
            stable_ff <= stable_in;
         end
      end
   end

   // Result register, loaded per accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         stable_row_ff <= stable_row_in;
         bounce_ff     <= bounce_in;
         settled_ff    <= settled_in;
         busy_ff       <= busy_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stable_row    = stable_row_ff;
   assign rsp_bounce_seen   = bounce_ff;
   assign rsp_settled       = settled_ff;
   assign rsp_debounce_busy = busy_ff;

endmodule : key_matrix_debouncer

`default_nettype wire

// ===== hdl/kmdeb_checker.sv =====
// Port-level checks for the key matrix debouncer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module kmdeb_checker (
   input wire                     clock,
   input wire                     reset,
   input wire                     req_valid,
   input wire                     req_ready,
   input wire                     rsp_valid,
   input wire                     rsp_ready,
   input kmdeb_pkg::row_bits_type rsp_stable_row,
   input wire                     rsp_bounce_seen,
   input wire                     rsp_settled,
   input wire                     rsp_debounce_busy
);
   import kmdeb_pkg::*;

   // An accepted request always yields a result in the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no result");

   // A commit leaves the counter at zero
   a_settled_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_settled |-> !rsp_debounce_busy)
      else $error("settled result still busy");

   // A bounce reloads the counter, so it is still running unless it ran out right away
   a_bounce_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bounce_seen |-> rsp_debounce_busy || rsp_settled)
      else $error("bounce left the counter idle without a commit");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stable_row))
      else $error("stalled result changed");

endmodule : kmdeb_checker

bind key_matrix_debouncer kmdeb_checker u_kmdeb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_stable_row    (rsp_stable_row),
   .rsp_bounce_seen   (rsp_bounce_seen),
   .rsp_settled       (rsp_settled),
   .rsp_debounce_busy (rsp_debounce_busy)
);

`default_nettype wire
